FILE: sv/pwmcap_pkg.sv
// Shared types and constants for the PWM high time, period and duty capture block.
`timescale 1ns / 1ps
package pwmcap_pkg;

   localparam int CounterBitsDefault = 16;
   localparam int StampBits          = 32;
   localparam int CaptureBits        = 16;
   localparam int OverflowBits       = 16;
   localparam int DutyBits           = 16;
   localparam int DivStepBits        = 4;

   typedef enum logic [1:0] {
      ACT_POLL     = 2'd0,
      ACT_OVERFLOW = 2'd1,
      ACT_CAPTURE  = 2'd2
   } action_type;

   typedef enum logic [2:0] {
      PH_IDLE  = 3'd0,
      PH_RISE1 = 3'd1,
      PH_FALL  = 3'd2,
      PH_RISE2 = 3'd3,
      PH_DONE  = 3'd4
   } phase_type;

   typedef enum logic [2:0] {
      CALC_IDLE = 3'd0,
      CALC_DIFF = 3'd1,
      CALC_INIT = 3'd2,
      CALC_DIV  = 3'd3,
      CALC_OUT  = 3'd4
   } calc_type;

endpackage

FILE: sv/pwm_high_period_duty_capture_top.sv
// PWM input capture: edge stamps, high time, period and bit-serial duty division.
// Readout: a readout poll runs the difference, range check, 16 one-bit divide steps and
//   output load in that order; a zero or saturated duty skips the divide steps.
// Input: poll, overflow and capture beats are taken back to back; after a readout poll
//   input is held off until the 16-step divider has loaded the output register.
// Reset: synchronous, active high; clears phase, divider state, overflow count, stamps and the response valid.
`timescale 1ns / 1ps
module pwm_high_period_duty_capture_top #(
   parameter int COUNTER_BITS = pwmcap_pkg::CounterBitsDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // capture_value[15:0], edge_is_rising[16], zero fill
   input  logic [1:0]  req_tuser,   // action[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [79:0] rsp_tdata,   // high_ticks[31:0], period_ticks[63:32], duty_fraction[79:64]
   output logic        rsp_tuser    // zero_period
);

   localparam int SB = pwmcap_pkg::StampBits;
   localparam int CB = pwmcap_pkg::CaptureBits;
   localparam int OB = pwmcap_pkg::OverflowBits;
   localparam int DB = pwmcap_pkg::DutyBits;
   localparam int NB = pwmcap_pkg::DivStepBits;
   localparam int MaskBits = (COUNTER_BITS < CB) ? COUNTER_BITS : CB;
   localparam logic [CB-1:0] CapMask = CB'((64'd1 << MaskBits) - 64'd1);
   localparam logic [NB-1:0] LastStep = NB'(DB - 1);

   pwmcap_pkg::phase_type phase_ff, phase_in;
   pwmcap_pkg::calc_type  calc_ff, calc_in;
   logic [OB-1:0]  ovf_ff, ovf_in;
   logic [SB-1:0]  stamp_ff [3];
   logic [SB-1:0]  stamp_in [3];
   logic [SB-1:0]  high_ff, high_in;
   logic [SB-1:0]  period_ff, period_in;
   logic [SB-1:0]  rem_ff, rem_in;
   logic [DB-1:0]  quot_ff, quot_in;
   logic           zero_ff, zero_in;
   logic [NB-1:0]  step_ff, step_in;
   logic           rsp_tvalid_ff, rsp_tvalid_in;
   logic [79:0]    rsp_tdata_ff, rsp_tdata_in;
   logic           rsp_tuser_ff, rsp_tuser_in;

   logic           accept;
   logic [CB-1:0]  cap;
   logic           rising;
   logic [63:0]    stamp_wide;
   logic [SB-1:0]  new_stamp;
   logic [SB:0]    rem_dbl;
   logic [SB:0]    rem_sub;

   assign req_tready = (calc_ff == pwmcap_pkg::CALC_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign cap        = req_tdata[CB-1:0] & CapMask;
   assign rising     = req_tdata[CB];
   assign stamp_wide = {{(64-CB){1'b0}}, cap} + ({{(64-OB){1'b0}}, ovf_ff} << COUNTER_BITS);
   assign new_stamp  = stamp_wide[SB-1:0];
   assign rem_dbl    = {rem_ff, 1'b0};
   assign rem_sub    = rem_dbl - {1'b0, period_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= pwmcap_pkg::PH_IDLE;
         calc_ff       <= pwmcap_pkg::CALC_IDLE;
         ovf_ff        <= '0;
         stamp_ff[0]   <= '0;
         stamp_ff[1]   <= '0;
         stamp_ff[2]   <= '0;
         step_ff       <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         calc_ff       <= calc_in;
         ovf_ff        <= ovf_in;
         stamp_ff[0]   <= stamp_in[0];
         stamp_ff[1]   <= stamp_in[1];
         stamp_ff[2]   <= stamp_in[2];
         step_ff       <= step_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      high_ff      <= high_in;
      period_ff    <= period_in;
      rem_ff       <= rem_in;
      quot_ff      <= quot_in;
      zero_ff      <= zero_in;
      rsp_tdata_ff <= rsp_tdata_in;
      rsp_tuser_ff <= rsp_tuser_in;
   end

   always_comb begin
      phase_in      = phase_ff;
      calc_in       = calc_ff;
      ovf_in        = ovf_ff;
      stamp_in[0]   = stamp_ff[0];
      stamp_in[1]   = stamp_ff[1];
      stamp_in[2]   = stamp_ff[2];
      high_in       = high_ff;
      period_in     = period_ff;
      rem_in        = rem_ff;
      quot_in       = quot_ff;
      zero_in       = zero_ff;
      step_in       = step_ff;
      rsp_tdata_in  = rsp_tdata_ff;
      rsp_tuser_in  = rsp_tuser_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;

      if (accept) begin
         case (req_tuser)
            pwmcap_pkg::ACT_POLL: begin
               if (phase_ff == pwmcap_pkg::PH_IDLE) begin
                  ovf_in      = '0;
                  stamp_in[0] = '0;
                  stamp_in[1] = '0;
                  stamp_in[2] = '0;
                  phase_in    = pwmcap_pkg::PH_RISE1;
               end else if (phase_ff == pwmcap_pkg::PH_DONE) begin
                  phase_in = pwmcap_pkg::PH_IDLE;
                  calc_in  = pwmcap_pkg::CALC_DIFF;
               end
            end
            pwmcap_pkg::ACT_OVERFLOW: begin
               if (phase_ff == pwmcap_pkg::PH_RISE1 || phase_ff == pwmcap_pkg::PH_FALL ||
                   phase_ff == pwmcap_pkg::PH_RISE2) begin
                  ovf_in = ovf_ff + OB'(1);
               end
            end
            pwmcap_pkg::ACT_CAPTURE: begin
               if (phase_ff == pwmcap_pkg::PH_RISE1 && rising) begin
                  stamp_in[0] = new_stamp;
                  phase_in    = pwmcap_pkg::PH_FALL;
               end else if (phase_ff == pwmcap_pkg::PH_FALL && !rising) begin
                  stamp_in[1] = new_stamp;
                  phase_in    = pwmcap_pkg::PH_RISE2;
               end else if (phase_ff == pwmcap_pkg::PH_RISE2 && rising) begin
                  stamp_in[2] = new_stamp;
                  phase_in    = pwmcap_pkg::PH_DONE;
               end
            end
            default: begin
            end
         endcase
      end

      unique case (calc_ff)
         pwmcap_pkg::CALC_IDLE: begin
         end
         pwmcap_pkg::CALC_DIFF: begin
            high_in   = stamp_ff[1] - stamp_ff[0];
            period_in = stamp_ff[2] - stamp_ff[0];
            calc_in   = pwmcap_pkg::CALC_INIT;
         end
         pwmcap_pkg::CALC_INIT: begin
            rem_in  = high_ff;
            quot_in = '0;
            step_in = '0;
            zero_in = 1'b0;
            if (period_ff == '0) begin
               zero_in = 1'b1;
               calc_in = pwmcap_pkg::CALC_OUT;
            end else if (high_ff >= period_ff) begin
               quot_in = '1;
               calc_in = pwmcap_pkg::CALC_OUT;
            end else begin
               calc_in = pwmcap_pkg::CALC_DIV;
            end
         end
         pwmcap_pkg::CALC_DIV: begin
            if (!rem_sub[SB]) begin
               rem_in  = rem_sub[SB-1:0];
               quot_in = {quot_ff[DB-2:0], 1'b1};
            end else begin
               rem_in  = rem_dbl[SB-1:0];
               quot_in = {quot_ff[DB-2:0], 1'b0};
            end
            step_in = step_ff + NB'(1);
            if (step_ff == LastStep) begin
               calc_in = pwmcap_pkg::CALC_OUT;
            end
         end
         pwmcap_pkg::CALC_OUT: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tvalid_in = 1'b1;
               rsp_tdata_in  = {quot_ff, period_ff, high_ff};
               rsp_tuser_in  = zero_ff;
               calc_in       = pwmcap_pkg::CALC_IDLE;
            end
         end
         default: begin
            calc_in = pwmcap_pkg::CALC_IDLE;
         end
      endcase
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

endmodule

FILE: tb/tb_top.sv
// Self-checking testbench for the PWM high time, period and duty capture block.
`timescale 1ns / 1ps
module tb_top;

   localparam logic [1:0] ACT_UNUSED = 2'd3;
   localparam int RandomEvents   = 1800;
   localparam int ModeSwitchA    = 600;
   localparam int ModeSwitchB    = 1200;
   localparam int HoldStart      = 1250;
   localparam int HoldCycles     = 400;
   localparam int DrainCycles    = 40;
   localparam int StallLimit     = 4000;

   typedef struct packed {
      logic [1:0]  action;
      logic [15:0] cap;
      logic        rising;
   } capture_event_type;

   typedef struct packed {
      logic [31:0] high_ticks;
      logic [31:0] period_ticks;
      logic [15:0] duty_fraction;
      logic        zero_period;
   } readout_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;   // capture_value[15:0], edge_is_rising[16], zero fill
   logic [1:0]  req_tuser = '0;   // action[1:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [79:0] rsp_tdata;        // high_ticks[31:0], period_ticks[63:32], duty_fraction[79:64]
   logic        rsp_tuser;        // zero_period

   capture_event_type pending_events[$];
   readout_type       expected_readouts[$];
   capture_event_type event_on_bus;

   pwmcap_pkg::phase_type meas_phase = pwmcap_pkg::PH_IDLE;
   logic [15:0] meas_overflows = '0;
   logic [31:0] meas_stamps[3] = '{default: '0};

   int events_sent = 0;
   int mismatches = 0;
   int send_idle_pct;
   int recv_idle_pct;
   int hold_left = 0;
   bit hold_done = 1'b0;
   int quiet_cycles = 0;

   pwm_high_period_duty_capture_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #4 clock = ~clock;

   always_comb begin
      if (events_sent < ModeSwitchA) begin
         send_idle_pct = 24;
         recv_idle_pct = 78;
      end else if (events_sent < ModeSwitchB) begin
         send_idle_pct = 78;
         recv_idle_pct = 24;
      end else begin
         send_idle_pct = 0;
         recv_idle_pct = 0;
      end
   end

   function automatic logic [31:0] stamp_of(logic [15:0] cap);
      logic [31:0] counter_mask;
      counter_mask = (32'd1 << pwmcap_pkg::CounterBitsDefault) - 32'd1;
      return (({16'd0, meas_overflows} << pwmcap_pkg::CounterBitsDefault) +
              ({16'd0, cap} & counter_mask));
   endfunction

   task automatic predict_capture(input capture_event_type ev);
      readout_type r;
      logic [47:0] quotient;
      case (ev.action)
         pwmcap_pkg::ACT_POLL: begin
            if (meas_phase == pwmcap_pkg::PH_IDLE) begin
               meas_overflows = '0;
               meas_stamps = '{default: '0};
               meas_phase = pwmcap_pkg::PH_RISE1;
            end else if (meas_phase == pwmcap_pkg::PH_DONE) begin
               r.high_ticks   = meas_stamps[1] - meas_stamps[0];
               r.period_ticks = meas_stamps[2] - meas_stamps[0];
               if (r.period_ticks == 32'd0) begin
                  r.duty_fraction = '0;
                  r.zero_period   = 1'b1;
               end else begin
                  quotient = {r.high_ticks, 16'd0} / {16'd0, r.period_ticks};
                  r.duty_fraction = (quotient > 48'hFFFF) ? 16'hFFFF : quotient[15:0];
                  r.zero_period   = 1'b0;
               end
               expected_readouts.push_back(r);
               meas_phase = pwmcap_pkg::PH_IDLE;
            end
         end
         pwmcap_pkg::ACT_OVERFLOW: begin
            if (meas_phase inside {pwmcap_pkg::PH_RISE1, pwmcap_pkg::PH_FALL,
                                   pwmcap_pkg::PH_RISE2})
               meas_overflows = meas_overflows + 16'd1;
         end
         pwmcap_pkg::ACT_CAPTURE: begin
            if (meas_phase == pwmcap_pkg::PH_RISE1 && ev.rising) begin
               meas_stamps[0] = stamp_of(ev.cap);
               meas_phase = pwmcap_pkg::PH_FALL;
            end else if (meas_phase == pwmcap_pkg::PH_FALL && !ev.rising) begin
               meas_stamps[1] = stamp_of(ev.cap);
               meas_phase = pwmcap_pkg::PH_RISE2;
            end else if (meas_phase == pwmcap_pkg::PH_RISE2 && ev.rising) begin
               meas_stamps[2] = stamp_of(ev.cap);
               meas_phase = pwmcap_pkg::PH_DONE;
            end
         end
         default: ;
      endcase
   endtask

   task automatic queue_event(logic [1:0] action, logic [15:0] cap, logic rising);
      capture_event_type ev;
      ev.action = action;
      ev.cap    = cap;
      ev.rising = rising;
      pending_events.push_back(ev);
   endtask

   function automatic logic [15:0] pick_cap();
      case ($urandom_range(0, 9))
         0: return 16'h0000;
         1: return 16'hFFFF;
         default: return 16'($urandom_range(0, 65535));
      endcase
   endfunction

   task automatic queue_overflows(int count);
      for (int i = 0; i < count; i++)
         queue_event(pwmcap_pkg::ACT_OVERFLOW, pick_cap(), 1'($urandom_range(0, 1)));
   endtask

   function automatic int pick_gap();
      return ($urandom_range(0, 9) == 0) ? int'($urandom_range(0, 40)) :
                                           int'($urandom_range(0, 2));
   endfunction

   // well-formed measurement: arm, rise, fall, rise, read out
   task automatic queue_measurement();
      logic [15:0] first_cap;
      int          gap;
      bit          flat;
      flat = ($urandom_range(0, 9) == 0);
      first_cap = pick_cap();
      queue_event(pwmcap_pkg::ACT_POLL, pick_cap(), 1'($urandom_range(0, 1)));
      gap = pick_gap();
      queue_overflows(gap);
      queue_event(pwmcap_pkg::ACT_CAPTURE, first_cap, 1'b1);
      if ($urandom_range(0, 9) == 0)
         queue_event(pwmcap_pkg::ACT_CAPTURE, pick_cap(), 1'b1);
      gap = flat ? 0 : pick_gap();
      queue_overflows(gap);
      queue_event(pwmcap_pkg::ACT_CAPTURE, flat ? first_cap : pick_cap(), 1'b0);
      gap = flat ? 0 : pick_gap();
      queue_overflows(gap);
      queue_event(pwmcap_pkg::ACT_CAPTURE, flat ? first_cap : pick_cap(), 1'b1);
      queue_event(pwmcap_pkg::ACT_POLL, pick_cap(), 1'($urandom_range(0, 1)));
   endtask

   task automatic queue_noise();
      int n;
      n = $urandom_range(1, 4);
      for (int i = 0; i < n; i++)
         queue_event(2'($urandom_range(0, 3)), pick_cap(), 1'($urandom_range(0, 1)));
   endtask

   task automatic check_readout(readout_type got);
      readout_type want;
      if (expected_readouts.size() == 0) begin
         $error("unexpected readout beat: high_ticks %0h period_ticks %0h",
                got.high_ticks, got.period_ticks);
         mismatches++;
         return;
      end
      want = expected_readouts.pop_front();
      if (got.high_ticks !== want.high_ticks) begin
         $error("high_ticks: expected %0h, actual %0h", want.high_ticks, got.high_ticks);
         mismatches++;
      end
      if (got.period_ticks !== want.period_ticks) begin
         $error("period_ticks: expected %0h, actual %0h", want.period_ticks, got.period_ticks);
         mismatches++;
      end
      if (got.duty_fraction !== want.duty_fraction) begin
         $error("duty_fraction: expected %0h, actual %0h",
                want.duty_fraction, got.duty_fraction);
         mismatches++;
      end
      if (got.zero_period !== want.zero_period) begin
         $error("zero_period: expected %0b, actual %0b", want.zero_period, got.zero_period);
         mismatches++;
      end
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            predict_capture(event_on_bus);
            events_sent <= events_sent + 1;
         end
         if (!req_tvalid || req_tready) begin
            if (pending_events.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               event_on_bus = pending_events.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= {7'd0, event_on_bus.rising, event_on_bus.cap};
               req_tuser  <= event_on_bus.action;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // monitor and receiver
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready)
            check_readout({rsp_tdata[31:0], rsp_tdata[63:32], rsp_tdata[79:64], rsp_tuser});
         if (!hold_done && events_sent >= HoldStart) begin
            hold_done  <= 1'b1;
            hold_left  <= HoldCycles;
            rsp_tready <= 1'b0;
         end else if (hold_left != 0) begin
            hold_left  <= hold_left - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= StallLimit) begin
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   initial begin
      // directed: ignored actions while idle, then polarity, zero period, saturation
      queue_event(ACT_UNUSED, 16'hFFFF, 1'b1);
      queue_event(pwmcap_pkg::ACT_OVERFLOW, 16'h0000, 1'b0);
      queue_event(pwmcap_pkg::ACT_CAPTURE, 16'h1111, 1'b1);
      queue_event(pwmcap_pkg::ACT_POLL, 16'h0000, 1'b0);
      queue_event(pwmcap_pkg::ACT_POLL, 16'hFFFF, 1'b1);
      queue_event(pwmcap_pkg::ACT_CAPTURE, 16'h2222, 1'b0);
      queue_event(pwmcap_pkg::ACT_CAPTURE, 16'hFFFF, 1'b1);
      queue_event(pwmcap_pkg::ACT_OVERFLOW, 16'hFFFF, 1'b1);
      queue_event(pwmcap_pkg::ACT_CAPTURE, 16'h3333, 1'b1);
      queue_event(pwmcap_pkg::ACT_CAPTURE, 16'h0000, 1'b0);
      queue_event(ACT_UNUSED, 16'h0000, 1'b0);
      queue_event(pwmcap_pkg::ACT_CAPTURE, 16'hFFFF, 1'b1);
      queue_event(pwmcap_pkg::ACT_OVERFLOW, 16'h0000, 1'b0);
      queue_event(pwmcap_pkg::ACT_CAPTURE, 16'h4444, 1'b0);
      queue_event(pwmcap_pkg::ACT_POLL, 16'h0000, 1'b0);
      queue_event(pwmcap_pkg::ACT_POLL, 16'h0000, 1'b0);
      queue_event(pwmcap_pkg::ACT_CAPTURE, 16'h1234, 1'b1);
      queue_event(pwmcap_pkg::ACT_CAPTURE, 16'h1234, 1'b0);
      queue_event(pwmcap_pkg::ACT_CAPTURE, 16'h1234, 1'b1);
      queue_event(pwmcap_pkg::ACT_POLL, 16'h0000, 1'b0);
      queue_event(pwmcap_pkg::ACT_POLL, 16'h0000, 1'b0);
      queue_event(pwmcap_pkg::ACT_CAPTURE, 16'h0000, 1'b1);
      queue_event(pwmcap_pkg::ACT_CAPTURE, 16'hFFFF, 1'b0);
      queue_event(pwmcap_pkg::ACT_CAPTURE, 16'h0001, 1'b1);
      queue_event(pwmcap_pkg::ACT_POLL, 16'h0000, 1'b0);

      while (pending_events.size() < RandomEvents) begin
         if ($urandom_range(0, 9) < 8)
            queue_measurement();
         else
            queue_noise();
      end

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      while (pending_events.size() != 0 || req_tvalid) @(posedge clock);
      while (expected_readouts.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);

      if (mismatches == 0 && expected_readouts.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

FILE: files.f
sv/pwmcap_pkg.sv
sv/pwm_high_period_duty_capture_top.sv
tb/tb_top.sv
